// ===== design/affine_matrix_inverse_top_assert.svh =====
// Assertion macros shared by the affine matrix inverse modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef AFFINE_MATRIX_INVERSE_TOP_ASSERT_SVH
`define AFFINE_MATRIX_INVERSE_TOP_ASSERT_SVH
// Same-cycle implication, disabled while reset is asserted.
`define AMI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define AMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/ami_pkg.sv =====
// Package for the affine matrix inverse: widths, constants and stage structs.
// No dependencies; every module of the block imports it.
package ami_pkg;
  localparam int FracBits = 16;
  localparam int WordW    = 32;
  localparam int WideW    = 2 * WordW;
  localparam int Lanes    = 6;
  localparam int TolW     = 16;
  localparam int DivSteps = WordW;

  localparam logic [WordW-1:0] One    = WordW'(1) << FracBits;
  localparam logic [WordW-1:0] PosMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic [WordW-1:0] NegMin = {1'b1, {(WordW-1){1'b0}}};

  typedef struct packed {
    logic [Lanes-1:0][WordW-1:0] term;
  } in_t;

  typedef struct packed {
    logic [Lanes-1:0][WideW-1:0] prod;
    logic [3:0][WordW-1:0]       lin;
  } mul_t;

  typedef struct packed {
    logic [Lanes-1:0][WideW-1:0] rem;
    logic [Lanes-1:0][WordW-1:0] dq;
    logic [Lanes-1:0]            neg;
    logic [Lanes-1:0]            ovf;
    logic                        singular;
    logic [WideW-1:0]            dmag;
  } div_t;

  typedef struct packed {
    logic [Lanes-1:0][WordW-1:0] inv;
    logic                        invertible;
  } res_t;
endpackage

// ===== design/ami_mul.sv =====
// First stage: the six 32 by 32 signed products of the inverse.
// Depends on ami_pkg.
module ami_mul import ami_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  in_t  data_i,
  output logic valid_o,
  output mul_t data_o
);
  logic signed [WideW-1:0] p [Lanes];
  mul_t mul_d, mul_q;
  logic vld_q;

  always_comb begin
    p[0] = $signed(data_i.term[0]) * $signed(data_i.term[3]);
    p[1] = $signed(data_i.term[1]) * $signed(data_i.term[2]);
    p[2] = $signed(data_i.term[2]) * $signed(data_i.term[5]);
    p[3] = $signed(data_i.term[3]) * $signed(data_i.term[4]);
    p[4] = $signed(data_i.term[1]) * $signed(data_i.term[4]);
    p[5] = $signed(data_i.term[0]) * $signed(data_i.term[5]);
    for (int l = 0; l < Lanes; l++) begin
      mul_d.prod[l] = p[l];
    end
    for (int l = 0; l < 4; l++) begin
      mul_d.lin[l] = data_i.term[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q <= mul_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = mul_q;
endmodule

// ===== design/ami_prep.sv =====
// Stages two to four: determinant and numerators, magnitudes and the
// singularity test, then the quotient range check. Depends on ami_pkg.
module ami_prep import ami_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [TolW-1:0] tol_i,
  input  logic            valid_i,
  input  mul_t            data_i,
  output logic            valid_o,
  output div_t            data_o
);
  logic [Lanes-1:0][WideW-1:0] num_d, num_q;
  logic [WideW-1:0]            det_d, det_q;
  logic [Lanes-1:0][WideW-1:0] mag_d, mag_q;
  logic [Lanes-1:0]            neg_d, neg_q;
  logic [WideW-1:0]            dmag_d, dmag_q;
  logic [WideW-1:0]            lim;
  logic                        sing_d, sing_q;
  div_t                        div_d, div_q;
  logic [2:0]                  vld_q;

  always_comb begin
    det_d    = data_i.prod[0] - data_i.prod[1];
    num_d[0] = WideW'($signed(data_i.lin[3])) <<< FracBits;
    num_d[1] = -(WideW'($signed(data_i.lin[1])) <<< FracBits);
    num_d[2] = -(WideW'($signed(data_i.lin[2])) <<< FracBits);
    num_d[3] = WideW'($signed(data_i.lin[0])) <<< FracBits;
    num_d[4] = data_i.prod[2] - data_i.prod[3];
    num_d[5] = data_i.prod[4] - data_i.prod[5];
  end

  always_comb begin
    lim    = WideW'(tol_i) << FracBits;
    dmag_d = det_q[WideW-1] ? -det_q : det_q;
    sing_d = (det_q == '0) || (dmag_d < lim);
    for (int l = 0; l < Lanes; l++) begin
      mag_d[l] = num_q[l][WideW-1] ? -num_q[l] : num_q[l];
      neg_d[l] = num_q[l][WideW-1] ^ det_q[WideW-1];
    end
  end

  always_comb begin
    div_d.singular = sing_q;
    div_d.dmag     = dmag_q;
    div_d.neg      = neg_q;
    for (int l = 0; l < Lanes; l++) begin
      div_d.ovf[l] = {{WordW{1'b0}}, mag_q[l]}
                     >= ({{WordW{1'b0}}, dmag_q} << (WordW - FracBits));
      div_d.rem[l] = mag_q[l] >> (WordW - FracBits);
      div_d.dq[l]  = WordW'(mag_q[l] << FracBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      det_q  <= det_d;
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      dmag_q <= dmag_d;
      sing_q <= sing_d;
      div_q  <= div_d;
    end
  end

  assign valid_o = vld_q[2];
  assign data_o  = div_q;
endmodule

// ===== design/ami_div.sv =====
// Six-lane restoring divider, one quotient bit per register stage.
// Depends on ami_pkg and the assertion macro header.
`include "affine_matrix_inverse_top_assert.svh"
module ami_div import ami_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);
  div_t                st_d [DivSteps];
  div_t                st_q [DivSteps];
  logic [DivSteps-1:0] vld_q;

  function automatic div_t div_step(div_t s);
    div_t        r;
    logic [WideW:0] t;
    logic [WideW:0] diff;
    r = s;
    for (int l = 0; l < Lanes; l++) begin
      t    = {s.rem[l], s.dq[l][WordW-1]};
      diff = t - {1'b0, s.dmag};
      if (!diff[WideW]) begin
        r.rem[l] = diff[WideW-1:0];
        r.dq[l]  = {s.dq[l][WordW-2:0], 1'b1};
      end else begin
        r.rem[l] = t[WideW-1:0];
        r.dq[l]  = {s.dq[l][WordW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_comb begin
    st_d[0] = div_step(data_i);
    for (int k = 1; k < DivSteps; k++) begin
      st_d[k] = div_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivSteps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivSteps; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign data_o  = st_q[DivSteps-1];

  `AMI_ASSERT_NEXT(a_div_hold, !en_i, $stable(vld_q), "divider moved while stalled")
  `AMI_ASSERT_SAME(a_div_nonzero, valid_o && !data_o.singular, data_o.dmag != '0,
                   "zero divisor reached the end of the divider")
endmodule

// ===== design/affine_matrix_inverse_top.sv =====
// Affine 2x3 matrix inverse in signed Q16.16 with a singularity flag.
// Depends on ami_pkg, ami_mul, ami_prep, ami_div and the assertion header.
//
// The slave stream takes one matrix per word; the master stream returns its
// inverse, with tuser high when the matrix was invertible and the identity
// matrix with tuser low when the determinant is zero or its magnitude lies
// below the tolerance register times 2^16.
// The tolerance is written through cfg_wr_en_i and cfg_wr_data_i; the user
// must do so only while the block is idle (not enforced); it resets to 1.
// An accepted input word reaches the master side through one multiply
// stage, three preparation stages, 32 divider stages (one quotient bit
// each) and the output register. Throughput is one word per cycle unless
// the receiver stalls with a result waiting; the pipeline advances together.
// When the receiver stalls with a result waiting, every stage holds and
// s_axis_tready_o drops, so nothing is lost or repeated.
// Reset clears all valid bits, empties the pipeline and restores the
// tolerance to 1.
`include "affine_matrix_inverse_top_assert.svh"
module affine_matrix_inverse_top import ami_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_wr_en_i,
  input  logic [TolW-1:0]         cfg_wr_data_i,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // a11, a12, a21, a22, shift_x, shift_y
  input  logic [Lanes*WordW-1:0]  s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // inv11, inv12, inv21, inv22, inv_shift_x, inv_shift_y
  output logic [Lanes*WordW-1:0]  m_axis_tdata_o,
  // invertible
  output logic                    m_axis_tuser_o
);
  logic            adv;
  logic [TolW-1:0] tol_q;
  in_t             in_data;
  logic            mul_vld, prep_vld, div_vld;
  mul_t            mul_data;
  div_t            prep_data, div_data;
  res_t            out_d, out_q;
  logic            out_valid_q;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign in_data         = s_axis_tdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolW'(1);
    end else if (cfg_wr_en_i) begin
      tol_q <= cfg_wr_data_i;
    end
  end

  ami_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid_i),
    .data_i  (in_data),
    .valid_o (mul_vld),
    .data_o  (mul_data)
  );

  ami_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .tol_i   (tol_q),
    .valid_i (mul_vld),
    .data_i  (mul_data),
    .valid_o (prep_vld),
    .data_o  (prep_data)
  );

  ami_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (prep_vld),
    .data_i  (prep_data),
    .valid_o (div_vld),
    .data_o  (div_data)
  );

  always_comb begin
    out_d.invertible = !div_data.singular;
    for (int l = 0; l < Lanes; l++) begin
      if (div_data.neg[l]) begin
        if (div_data.ovf[l] || (div_data.dq[l] > NegMin)) begin
          out_d.inv[l] = NegMin;
        end else begin
          out_d.inv[l] = -div_data.dq[l];
        end
      end else if (div_data.ovf[l] || div_data.dq[l][WordW-1]) begin
        out_d.inv[l] = PosMax;
      end else begin
        out_d.inv[l] = div_data.dq[l];
      end
    end
    if (div_data.singular) begin
      out_d.inv    = '0;
      out_d.inv[0] = One;
      out_d.inv[3] = One;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.inv;
  assign m_axis_tuser_o  = out_q.invertible;

  `AMI_ASSERT_SAME(a_top_identity, out_valid_q && !out_q.invertible,
                   (out_q.inv[0] == One) && (out_q.inv[3] == One) && (out_q.inv[1] == '0)
                   && (out_q.inv[2] == '0) && (out_q.inv[4] == '0) && (out_q.inv[5] == '0),
                   "singular result is not the identity")
endmodule

// ===== tb/sv/tb_affine_matrix_inverse_top.sv =====
// Self-checking testbench for affine_matrix_inverse_top: drives matrices on the slave
// stream, predicts each inverse and compares it with the master stream word by word.
// Depends on ami_pkg and the block's RTL.
module tb_affine_matrix_inverse_top;
  import ami_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] sy, sx, m22, m21, m12, m11;
  } mat_t;

  typedef struct packed {
    logic             flag;
    logic [WordW-1:0] sy, sx, i22, i21, i12, i11;
  } inv_t;

  typedef struct {
    mat_t m;
    bit   known;
    inv_t res;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_wr_en_i = 1'b0;
  logic [TolW-1:0]        cfg_wr_data_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [Lanes*WordW-1:0] s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [Lanes*WordW-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  affine_matrix_inverse_top DUT (.*);

  always #5 clk_i = ~clk_i;

  logic [TolW-1:0] tol_reg;
  inv_t            pending_inv[$];
  int              errors = 0;
  int              n_sent = 0;
  int              n_recv = 0;
  int              n_sing = 0;
  int              cycles = 0;
  int              src_idle = 0;
  int              snk_idle = 0;
  localparam int   CycleLimit = 400000;
  localparam logic [WordW-1:0] Mx = PosMax;
  localparam logic [WordW-1:0] Mn = NegMin;

  function automatic logic [WordW-1:0] q_div(logic signed [WideW+FracBits-1:0] num,
                                             logic signed [WideW-1:0] den);
    logic signed [WideW+FracBits-1:0] q;
    q = (num <<< FracBits) / den;
    if (q > $signed({1'b0, Mx})) return Mx;
    if (q < -$signed({1'b0, Mn})) return Mn;
    return q[WordW-1:0];
  endfunction

  function automatic inv_t invert(mat_t m);
    logic signed [WideW-1:0] a, b, c, d, x, y, det, mag;
    inv_t r;
    a = $signed(m.m11); b = $signed(m.m12); c = $signed(m.m21); d = $signed(m.m22);
    x = $signed(m.sx);  y = $signed(m.sy);
    det = a * d - b * c;
    mag = det < 0 ? -det : det;
    if (det == 0 || $unsigned(mag) < ({48'd0, tol_reg} << FracBits)) begin
      r = '0;
      r.i11 = One;
      r.i22 = One;
      return r;
    end
    r.i11 = q_div(d <<< FracBits, det);
    r.i12 = q_div(-b <<< FracBits, det);
    r.i21 = q_div(-c <<< FracBits, det);
    r.i22 = q_div(a <<< FracBits, det);
    r.sx = q_div(c * y - d * x, det);
    r.sy = q_div(b * x - a * y, det);
    r.flag = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i) begin
    inv_t got, want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("tb_affine_matrix_inverse_top: errors");
      $finish;
    end
    if (rst_ni) begin
      m_axis_tready_i <= ($urandom_range(99) >= snk_idle);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tuser_o, m_axis_tdata_o};
        n_recv <= n_recv + 1;
        if (pending_inv.size() == 0) begin
          errors++;
          $display("%0t unexpected word %h", $time, got);
        end else begin
          want = pending_inv.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t mismatch exp %h act %h", $time, want, got);
          end
        end
      end
    end
  end

  task automatic send(mat_t m, bit known, inv_t res);
    inv_t p;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= m;
    p = invert(m);
    if (known && p !== res) begin
      errors++;
      $display("%0t table mismatch exp %h act %h", $time, res, p);
    end
    pending_inv.push_back(p);
    n_sent++;
    if (p.flag == 1'b0) n_sing++;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain_and_set(logic [TolW-1:0] v);
    s_axis_tvalid_i <= 1'b0;
    while (pending_inv.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    tol_reg = v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  function automatic logic [WordW-1:0] rnd_term();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(3) == 0 ? Mx : Mn;
      2: return WordW'($signed($urandom_range(8 << FracBits)) - (4 << FracBits));
      3: return WordW'($signed($urandom_range(511)) - 256);
      default: return WordW'($signed($urandom_range(2 << FracBits)) - (1 << FracBits));
    endcase
  endfunction

  function automatic mat_t rnd_mat();
    mat_t m;
    m = {rnd_term(), rnd_term(), rnd_term(), rnd_term(), rnd_term(), rnd_term()};
    if ($urandom_range(7) == 0) begin
      m.m21 = m.m11;
      m.m22 = m.m12;
    end
    return m;
  endfunction

  initial begin
    row_t tbl[$];
    inv_t ident, unit;
    logic [TolW-1:0] tols[5];
    ident = '0; ident.i11 = One; ident.i22 = One;
    unit = ident; unit.flag = 1'b1;
    tols = '{16'd0, 16'hFFFF, 16'd1, 16'd200, 16'd0};
    tol_reg = 16'd1;
    tbl.push_back('{'{'0, '0, One, '0, '0, One}, 1, unit});
    tbl.push_back('{'{'0, '0, '0, '0, '0, '0}, 1, ident});
    tbl.push_back('{'{Mx, Mn, One, One, One, One}, 1, ident});
    tbl.push_back('{'{Mx, Mx, Mx, '0, '0, Mx}, 0, '0});
    tbl.push_back('{'{Mn, Mn, Mn, '0, '0, Mn}, 0, '0});
    tbl.push_back('{'{Mx, Mn, 32'd1, '0, '0, 32'd1}, 0, '0});
    tbl.push_back('{'{Mn, Mx, Mn, Mx, Mx, Mn}, 0, '0});
    tbl.push_back('{'{32'd5, 32'd7, 32'd255, '0, '0, 32'd255}, 1, ident});
    tbl.push_back('{'{32'd5, 32'd7, 32'd256, '0, '0, 32'd256}, 0, '0});
    tbl.push_back('{'{'1, '1, 32'd3, 32'd2, 32'd5, 32'h7}, 0, '0});
    tbl.push_back('{'{32'hFFFF_FFFF, '0, '1, One, One, '1}, 0, '0});
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (tbl[i]) send(tbl[i].m, tbl[i].known, tbl[i].res);
    drain_and_set(16'd0);
    send('{'0, '0, '0, '0, '0, '0}, 1, ident);
    send('{'0, '0, 32'd1, '0, '0, 32'd1}, 0, '0);
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = ph == 0 ? 38 : ph == 1 ? 51 : 0;
      snk_idle = ph == 0 ? 51 : ph == 1 ? 38 : 0;
      for (int s = 0; s < 5; s++) begin
        if (s != 0 || ph != 0) drain_and_set(tols[s]);
        for (int k = 0; k < 95; k++) send(rnd_mat(), 0, '0);
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending_inv.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d matrices (%0d singular), received %0d inverses,", n_sent, n_sing, n_recv);
    $display("over five tolerance settings and three idling patterns.");
    if (errors == 0) $display("tb_affine_matrix_inverse_top: clean");
    else $display("tb_affine_matrix_inverse_top: errors");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/ami_pkg.sv
design/ami_mul.sv
design/ami_prep.sv
design/ami_div.sv
design/affine_matrix_inverse_top.sv
tb/sv/tb_affine_matrix_inverse_top.sv
